[hw/rtl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and constants of the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int LEN_BITS = 16;
    localparam int LEN_BITS_MAX = 32;

    // bus engine status codes
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
    localparam logic [7:0] ST_DATAW_ACK  = 8'h28;
    localparam logic [7:0] ST_DATAW_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
    localparam logic [7:0] ST_DATAR_ACK  = 8'h50;
    localparam logic [7:0] ST_DATAR_NACK = 8'h58;
    localparam logic [7:0] ST_NO_INFO    = 8'hF8;

    // item commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_PROTOCOL   = 3'd1;
    localparam logic [2:0] ERR_SLAW_NACK  = 3'd2;
    localparam logic [2:0] ERR_DATA_NACK  = 3'd3;
    localparam logic [2:0] ERR_SLAR_NACK  = 3'd4;
    localparam logic [2:0] ERR_EARLY_NACK = 3'd5;
    localparam logic [2:0] ERR_ARB_LOST   = 3'd6;

    // ack control codes
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [3:0] {
        EV_NOP        = 4'd0,
        EV_START      = 4'd1,
        EV_START_SENT = 4'd2,
        EV_SLAW_ACK   = 4'd3,
        EV_SLAW_NACK  = 4'd4,
        EV_DATAW_ACK  = 4'd5,
        EV_DATAW_NACK = 4'd6,
        EV_RESTART    = 4'd7,
        EV_SLAR_ACK   = 4'd8,
        EV_SLAR_NACK  = 4'd9,
        EV_DATAR_ACK  = 4'd10,
        EV_DATAR_NACK = 4'd11,
        EV_ARB_LOST   = 4'd12,
        EV_BAD        = 4'd13
    } t_event;

    typedef struct packed {
        t_event      ev;
        logic [6:0]  slave_addr;
        logic [15:0] write_len;
        logic [15:0] read_len;
        logic [7:0]  rx_byte;
        logic [7:0]  next_tx_byte;
    } t_entry;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_START   = 7'b0000010,
        PH_SLAW    = 7'b0000100,
        PH_DATAW   = 7'b0001000,
        PH_RESTART = 7'b0010000,
        PH_SLAR    = 7'b0100000,
        PH_DATAR   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic        set_start;
        logic        set_stop;
        logic        clear_start;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  ack_control;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        done_res;
        logic [2:0]  error_code;
        logic [15:0] received_count;
    } t_result;

endpackage

[hw/rtl/i2cms_if.sv]
// ----------------------------------------------------------------------------
// i2cms_if
// Valid/ready channels of the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
interface i2cms_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [6:0]  slave_addr;
    logic [15:0] write_len;
    logic [15:0] read_len;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  next_tx_byte;

    modport source (
        output valid, cmd, slave_addr, write_len, read_len, status_code, rx_byte,
               next_tx_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, slave_addr, write_len, read_len, status_code, rx_byte,
               next_tx_byte,
        output ready
    );
endinterface

interface i2cms_out_if;
    logic        valid;
    logic        ready;
    logic        set_start;
    logic        set_stop;
    logic        clear_start;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  ack_control;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        done_res;
    logic [2:0]  error_code;
    logic [15:0] received_count;

    modport source (
        output valid, set_start, set_stop, clear_start, tx_valid, tx_byte, ack_control,
               rx_valid, rx_data, done_res, error_code, received_count,
        input  ready
    );
    modport sink (
        input  valid, set_start, set_stop, clear_start, tx_valid, tx_byte, ack_control,
               rx_valid, rx_data, done_res, error_code, received_count,
        output ready
    );
endinterface

[hw/rtl/i2cms_front.sv]
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts items and classifies start commands and bus status codes.
// ----------------------------------------------------------------------------
module i2cms_front #(
    parameter int LEN_BITS = i2cms_pkg::LEN_BITS
) (
    i2cms_in_if.sink          i_item,
    input  logic              i_full,
    output logic              o_push,
    output i2cms_pkg::t_entry o_entry
);

    logic [LEN_BITS-1:0] wl;
    logic [LEN_BITS-1:0] rl;
    i2cms_pkg::t_event   ev;

    assign wl = LEN_BITS'(32'(i_item.write_len));
    assign rl = LEN_BITS'(32'(i_item.read_len));

    always_comb begin
        if (i_item.cmd == i2cms_pkg::CMD_START) begin
            ev = ((wl != '0) || (rl != '0)) ? i2cms_pkg::EV_START : i2cms_pkg::EV_NOP;
        end else begin
            unique case (i_item.status_code)
                i2cms_pkg::ST_NO_INFO:    ev = i2cms_pkg::EV_NOP;
                i2cms_pkg::ST_START:      ev = i2cms_pkg::EV_START_SENT;
                i2cms_pkg::ST_SLAW_ACK:   ev = i2cms_pkg::EV_SLAW_ACK;
                i2cms_pkg::ST_SLAW_NACK:  ev = i2cms_pkg::EV_SLAW_NACK;
                i2cms_pkg::ST_DATAW_ACK:  ev = i2cms_pkg::EV_DATAW_ACK;
                i2cms_pkg::ST_DATAW_NACK: ev = i2cms_pkg::EV_DATAW_NACK;
                i2cms_pkg::ST_RESTART:    ev = i2cms_pkg::EV_RESTART;
                i2cms_pkg::ST_SLAR_ACK:   ev = i2cms_pkg::EV_SLAR_ACK;
                i2cms_pkg::ST_SLAR_NACK:  ev = i2cms_pkg::EV_SLAR_NACK;
                i2cms_pkg::ST_DATAR_ACK:  ev = i2cms_pkg::EV_DATAR_ACK;
                i2cms_pkg::ST_DATAR_NACK: ev = i2cms_pkg::EV_DATAR_NACK;
                i2cms_pkg::ST_ARB_LOST:   ev = i2cms_pkg::EV_ARB_LOST;
                default:                  ev = i2cms_pkg::EV_BAD;
            endcase
        end
    end

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    assign o_entry.ev           = ev;
    assign o_entry.slave_addr   = i_item.slave_addr;
    assign o_entry.write_len    = i_item.write_len;
    assign o_entry.read_len     = i_item.read_len;
    assign o_entry.rx_byte      = i_item.rx_byte;
    assign o_entry.next_tx_byte = i_item.next_tx_byte;

endmodule

[hw/rtl/i2cms_queue.sv]
// ----------------------------------------------------------------------------
// i2cms_queue
// Short fifo of classified items between the front and the back.
// ----------------------------------------------------------------------------
module i2cms_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cms_pkg::t_entry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output i2cms_pkg::t_entry o_entry
);

    i2cms_pkg::t_entry                 r_mem [i2cms_pkg::Q_DEPTH];
    logic [i2cms_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [i2cms_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [i2cms_pkg::Q_CNT_W-1:0]     r_count;
    logic                              do_pop;

    assign o_full  = (r_count == i2cms_pkg::Q_CNT_W'(i2cms_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/i2cms_back.sv]
// ----------------------------------------------------------------------------
// i2cms_back
// Transfer phase machine with counters and registered result stage.
// ----------------------------------------------------------------------------
module i2cms_back #(
    parameter int LEN_BITS = i2cms_pkg::LEN_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  i2cms_pkg::t_entry i_entry,
    output logic              o_pop,
    i2cms_out_if.source       o_result
);

    i2cms_pkg::t_phase   r_phase;
    i2cms_pkg::t_phase   n_phase;
    logic [6:0]          r_addr;
    logic [6:0]          n_addr;
    logic [LEN_BITS-1:0] r_writes_left;
    logic [LEN_BITS-1:0] n_writes_left;
    logic [LEN_BITS-1:0] r_reads_left;
    logic [LEN_BITS-1:0] n_reads_left;
    logic [LEN_BITS-1:0] r_reads_done;
    logic [LEN_BITS-1:0] n_reads_done;
    logic [2:0]          r_err;
    logic [2:0]          n_err;
    logic                r_out_valid;
    i2cms_pkg::t_result  r_res;
    i2cms_pkg::t_result  n_res;

    logic                fire;
    logic [7:0]          addr_w;
    logic [LEN_BITS-1:0] rl_dec;
    logic [LEN_BITS-1:0] wl_dec;
    logic [LEN_BITS-1:0] rd_inc;

    assign fire   = i_valid && (!r_out_valid || o_result.ready);
    assign o_pop  = fire;
    assign addr_w = {r_addr, 1'b0};
    assign rl_dec = (r_reads_left != '0) ? r_reads_left - LEN_BITS'(1) : r_reads_left;
    assign wl_dec = (r_writes_left != '0) ? r_writes_left - LEN_BITS'(1) : r_writes_left;
    assign rd_inc = (r_reads_done != '1) ? r_reads_done + LEN_BITS'(1) : r_reads_done;

    always_comb begin
        logic       fin;
        logic [2:0] fin_err;

        n_phase       = r_phase;
        n_addr        = r_addr;
        n_writes_left = r_writes_left;
        n_reads_left  = r_reads_left;
        n_reads_done  = r_reads_done;
        n_err         = r_err;
        n_res         = '0;
        fin           = 1'b0;
        fin_err       = i2cms_pkg::ERR_NONE;

        unique case (i_entry.ev)
            i2cms_pkg::EV_NOP: begin
            end
            i2cms_pkg::EV_START: begin
                if (r_phase == i2cms_pkg::PH_IDLE) begin
                    n_err           = i2cms_pkg::ERR_NONE;
                    n_addr          = i_entry.slave_addr;
                    n_writes_left   = LEN_BITS'(32'(i_entry.write_len));
                    n_reads_left    = LEN_BITS'(32'(i_entry.read_len));
                    n_reads_done    = '0;
                    n_phase         = i2cms_pkg::PH_START;
                    n_res.set_start = 1'b1;
                end
            end
            i2cms_pkg::EV_START_SENT: begin
                n_res.tx_valid    = 1'b1;
                n_res.clear_start = 1'b1;
                if (r_writes_left != '0) begin
                    n_phase       = i2cms_pkg::PH_SLAW;
                    n_res.tx_byte = addr_w;
                end else begin
                    n_phase       = i2cms_pkg::PH_SLAR;
                    n_res.tx_byte = addr_w | 8'h01;
                end
            end
            i2cms_pkg::EV_SLAW_ACK: begin
                if (r_phase == i2cms_pkg::PH_SLAW) begin
                    n_phase        = i2cms_pkg::PH_DATAW;
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = i_entry.next_tx_byte;
                    n_writes_left  = wl_dec;
                end else begin
                    fin     = 1'b1;
                    fin_err = i2cms_pkg::ERR_PROTOCOL;
                end
            end
            i2cms_pkg::EV_SLAW_NACK: begin
                fin     = 1'b1;
                fin_err = (r_phase == i2cms_pkg::PH_SLAW) ? i2cms_pkg::ERR_SLAW_NACK
                                                          : i2cms_pkg::ERR_PROTOCOL;
            end
            i2cms_pkg::EV_DATAW_ACK: begin
                if (r_phase != i2cms_pkg::PH_DATAW) begin
                    fin     = 1'b1;
                    fin_err = i2cms_pkg::ERR_PROTOCOL;
                end else if (r_writes_left != '0) begin
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = i_entry.next_tx_byte;
                    n_writes_left  = wl_dec;
                end else if (r_reads_left != '0) begin
                    n_phase         = i2cms_pkg::PH_RESTART;
                    n_res.set_start = 1'b1;
                end else begin
                    fin = 1'b1;
                end
            end
            i2cms_pkg::EV_DATAW_NACK: begin
                fin     = 1'b1;
                fin_err = (r_phase == i2cms_pkg::PH_DATAW) ? i2cms_pkg::ERR_DATA_NACK
                                                           : i2cms_pkg::ERR_PROTOCOL;
            end
            i2cms_pkg::EV_RESTART: begin
                if (r_phase == i2cms_pkg::PH_RESTART) begin
                    n_phase           = i2cms_pkg::PH_SLAR;
                    n_res.tx_valid    = 1'b1;
                    n_res.tx_byte     = addr_w | 8'h01;
                    n_res.clear_start = 1'b1;
                end else begin
                    fin     = 1'b1;
                    fin_err = i2cms_pkg::ERR_PROTOCOL;
                end
            end
            i2cms_pkg::EV_SLAR_ACK: begin
                if (r_phase == i2cms_pkg::PH_SLAR) begin
                    n_phase           = i2cms_pkg::PH_DATAR;
                    n_res.ack_control = (r_reads_left <= LEN_BITS'(1)) ? i2cms_pkg::ACK_NACK
                                                                       : i2cms_pkg::ACK_ACK;
                end else begin
                    fin     = 1'b1;
                    fin_err = i2cms_pkg::ERR_PROTOCOL;
                end
            end
            i2cms_pkg::EV_SLAR_NACK: begin
                fin     = 1'b1;
                fin_err = (r_phase == i2cms_pkg::PH_SLAR) ? i2cms_pkg::ERR_SLAR_NACK
                                                          : i2cms_pkg::ERR_PROTOCOL;
            end
            i2cms_pkg::EV_DATAR_ACK: begin
                if (r_phase == i2cms_pkg::PH_DATAR) begin
                    n_res.rx_valid    = 1'b1;
                    n_res.rx_data     = i_entry.rx_byte;
                    n_reads_done      = rd_inc;
                    n_reads_left      = rl_dec;
                    n_res.ack_control = (rl_dec <= LEN_BITS'(1)) ? i2cms_pkg::ACK_NACK
                                                                 : i2cms_pkg::ACK_ACK;
                end else begin
                    fin     = 1'b1;
                    fin_err = i2cms_pkg::ERR_PROTOCOL;
                end
            end
            i2cms_pkg::EV_DATAR_NACK: begin
                fin = 1'b1;
                if (r_phase == i2cms_pkg::PH_DATAR) begin
                    n_res.rx_valid = 1'b1;
                    n_res.rx_data  = i_entry.rx_byte;
                    n_reads_done   = rd_inc;
                    n_reads_left   = rl_dec;
                    fin_err        = (rl_dec != '0) ? i2cms_pkg::ERR_EARLY_NACK
                                                    : i2cms_pkg::ERR_NONE;
                end else begin
                    fin_err = i2cms_pkg::ERR_PROTOCOL;
                end
            end
            i2cms_pkg::EV_ARB_LOST: begin
                fin     = 1'b1;
                fin_err = i2cms_pkg::ERR_ARB_LOST;
            end
            default: begin
                fin     = 1'b1;
                fin_err = i2cms_pkg::ERR_PROTOCOL;
            end
        endcase

        if (fin) begin
            n_phase        = i2cms_pkg::PH_IDLE;
            n_res.set_stop = 1'b1;
            n_res.done_res = 1'b1;
            if (fin_err != i2cms_pkg::ERR_NONE) begin
                n_err = fin_err;
            end
        end

        n_res.error_code     = n_err;
        n_res.received_count = 16'(32'(n_reads_done));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= i2cms_pkg::PH_IDLE;
            r_addr        <= '0;
            r_writes_left <= '0;
            r_reads_left  <= '0;
            r_reads_done  <= '0;
            r_err         <= i2cms_pkg::ERR_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_phase       <= n_phase;
                r_addr        <= n_addr;
                r_writes_left <= n_writes_left;
                r_reads_left  <= n_reads_left;
                r_reads_done  <= n_reads_done;
                r_err         <= n_err;
                r_out_valid   <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.set_start      = r_res.set_start;
    assign o_result.set_stop       = r_res.set_stop;
    assign o_result.clear_start    = r_res.clear_start;
    assign o_result.tx_valid       = r_res.tx_valid;
    assign o_result.tx_byte        = r_res.tx_byte;
    assign o_result.ack_control    = r_res.ack_control;
    assign o_result.rx_valid       = r_res.rx_valid;
    assign o_result.rx_data        = r_res.rx_data;
    assign o_result.done_res       = r_res.done_res;
    assign o_result.error_code     = r_res.error_code;
    assign o_result.received_count = r_res.received_count;

endmodule

[hw/rtl/i2c_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Sequences an i2c master write-then-read transfer from bus status codes.
//
// i_item carries a start command (address, write and read length) or a bus
// status event (status code, received byte, next byte to send). Every
// accepted item gives exactly one transfer on o_result with the start/stop
// requests, the byte to load, the ack choice, the received byte, done and
// the error code.
// An accepted item is written into the queue and then into the result register,
// from which o_result takes it; a stall on o_result holds it in the queue.
// Throughput: one item per cycle while o_result is not stalled, set by the
// phase machine in the back end; a two-entry queue separates the classifying
// front end from it. When o_result stalls, the result register holds and the
// queue fills; i_item drops ready only once both queue entries are taken.
// Reset (synchronous, active low) empties the queue and the result stage and
// returns the phase to idle with all counts and the error cleared.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
    parameter int LEN_BITS = i2cms_pkg::LEN_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cms_in_if.sink    i_item,
    i2cms_out_if.source o_result
);

    logic              push;
    logic              full;
    logic              pop;
    logic              head_valid;
    i2cms_pkg::t_entry push_entry;
    i2cms_pkg::t_entry head_entry;

    i2cms_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    i2cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_entry (head_entry)
    );

    i2cms_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
